// ----- design/dzr_pkg.sv -----
// Shared types, constants and helpers for the diagonal zigzag reorder unit.
// No dependencies; every other design file refers to this package by scope.
package dzr_pkg;

    localparam int DATA_W       = 32;
    localparam int CFG_W        = 4;
    localparam int CFG_IDX_W    = 1;
    localparam int DEF_MAX_ROWS = 8;
    localparam int DEF_MAX_COLS = 8;
    localparam int FIFO_DEPTH   = 2;

    localparam logic [CFG_W-1:0] CFG_DIM_RESET = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_ROWS = 1'b0,
        REG_NUM_COLS = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        ST_LOAD = 1'b0,
        ST_SCAN = 1'b1
    } state_t;

    // One result word as it travels from the store read to the output queue.
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              last;
    } out_word_t;

    // Zero counts as one, anything above the maximum counts as the maximum.
    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] maxv);
        logic [CFG_W-1:0] res;
        if (v == '0)
            res = {{(CFG_W-1){1'b0}}, 1'b1};
        else if (v > maxv)
            res = maxv;
        else
            res = v;
        return res;
    endfunction

endpackage

// ----- design/dzr_store.sv -----
// Element store: one write port, one read port, registered read data.
// Depends on dzr_pkg for the data width.
module dzr_store #(
    parameter int DEPTH = dzr_pkg::DEF_MAX_ROWS * dzr_pkg::DEF_MAX_COLS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [dzr_pkg::DATA_W-1:0] wdata,
    input  logic                      re,
    input  logic [AW-1:0]             raddr,
    output logic [dzr_pkg::DATA_W-1:0] rdata
);

    logic [dzr_pkg::DATA_W-1:0] mem [DEPTH];
    logic [dzr_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/dzr_scan.sv -----
// Zigzag address sequencer: walks (row, col) along the diagonals of the block.
// Depends on dzr_pkg; driven by the top-level control state machine.
module dzr_scan #(
    parameter int MAX_ROWS = dzr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = dzr_pkg::DEF_MAX_COLS,
    parameter int RCW      = $clog2(MAX_ROWS + 1),
    parameter int CCW      = $clog2(MAX_COLS + 1),
    parameter int AW       = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           advance,
    input  logic [RCW-1:0] rows,
    input  logic [CCW-1:0] cols,
    output logic [AW-1:0]  addr,
    output logic           last
);

    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DW = $clog2(MAX_ROWS + MAX_COLS);
    localparam int PW = RW + CCW;

    logic [RW-1:0] r_reg, r_next;
    logic [CW-1:0] c_reg, c_next;
    logic [DW-1:0] d_reg, d_next;

    logic [DW-1:0] rows_m1, cols_m1, r_ext, c_ext, d_end, d_inc, r0, c0;
    logic          step_even, step_odd, in_diag;
    logic [PW-1:0] lin;

    always_comb
    begin
        rows_m1   = DW'(rows) - DW'(1);
        cols_m1   = DW'(cols) - DW'(1);
        r_ext     = DW'(r_reg);
        c_ext     = DW'(c_reg);
        d_end     = DW'(rows) + DW'(cols) - DW'(2);
        step_even = (r_ext != '0) && (c_ext < cols_m1);
        step_odd  = (c_ext != '0) && (r_ext < rows_m1);
        in_diag   = d_reg[0] ? step_odd : step_even;
        last      = !in_diag && (d_reg == d_end);

        // Entry point of the next diagonal.
        d_inc = d_reg + DW'(1);
        if (!d_inc[0])
        begin
            r0 = (d_inc < rows_m1) ? d_inc : rows_m1;
            c0 = d_inc - r0;
        end
        else
        begin
            c0 = (d_inc < cols_m1) ? d_inc : cols_m1;
            r0 = d_inc - c0;
        end

        r_next = r_reg;
        c_next = c_reg;
        d_next = d_reg;
        if (start)
        begin
            r_next = '0;
            c_next = '0;
            d_next = '0;
        end
        else if (advance)
        begin
            if (in_diag && !d_reg[0])
            begin
                r_next = r_reg - RW'(1);
                c_next = c_reg + CW'(1);
            end
            else if (in_diag)
            begin
                r_next = r_reg + RW'(1);
                c_next = c_reg - CW'(1);
            end
            else
            begin
                r_next = RW'(r0);
                c_next = CW'(c0);
                d_next = d_inc;
            end
        end

        lin  = PW'(r_reg) * PW'(cols) + PW'(c_reg);
        addr = AW'(lin);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg <= '0;
            c_reg <= '0;
            d_reg <= '0;
        end
        else
        begin
            r_reg <= r_next;
            c_reg <= c_next;
            d_reg <= d_next;
        end
    end

endmodule

// ----- design/dzr_out_fifo.sv -----
// Two-entry output queue that decouples store reads from the master port.
// Depends on dzr_pkg for the result word type and depth.
module dzr_out_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  dzr_pkg::out_word_t push_word,
    input  logic               pop,
    output dzr_pkg::out_word_t head_word,
    output logic               not_empty,
    output logic [1:0]         count
);

    dzr_pkg::out_word_t slot [dzr_pkg::FIFO_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot[wr_ptr_reg] <= push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head_word = slot[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

// ----- design/diagonal_zigzag_reorder_unit.sv -----
// Top level of the diagonal zigzag reorder unit: control, configuration and ports.
// Depends on dzr_pkg, dzr_store, dzr_scan and dzr_out_fifo.
//
// Takes matrix elements in row-major order on the slave port, one word per
// cycle while loading, into an element store of MAX_ROWS x MAX_COLS entries.
// The word that completes a block of num_rows x num_cols elements starts the
// emission: the sequencer walks the diagonals (even ones up and to the right,
// odd ones down and to the left) and reads one entry per cycle, while the
// queue has room, through the single read port of the store. Results go
// through a two-entry queue to the master port. s_tready is low during the
// emission sweep; words of the next block are taken again while the tail of
// the previous block still drains. m_tlast marks the final word of a block.
// num_rows and num_cols read 0 as 1 and clip values above the maximum; write
// them only while the unit is idle. The store has no reset.
module diagonal_zigzag_reorder_unit #(
    parameter int MAX_ROWS = dzr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = dzr_pkg::DEF_MAX_COLS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // slave port, tdata: [31:0] element (signed)
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dzr_pkg::DATA_W-1:0]    s_tdata,
    // master port, tdata: [31:0] out_element (signed); tlast: last
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dzr_pkg::DATA_W-1:0]    m_tdata,
    output logic                          m_tlast,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [dzr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dzr_pkg::CFG_W-1:0]     cfg_wdata
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RCW   = $clog2(MAX_ROWS + 1);
    localparam int CCW   = $clog2(MAX_COLS + 1);
    localparam int LCW   = $clog2(DEPTH + 1);
    localparam int SZW   = RCW + CCW;

    dzr_pkg::state_t             state_reg, state_next;
    logic [dzr_pkg::CFG_W-1:0]   num_rows_reg, num_cols_reg;
    logic [LCW-1:0]              load_count_reg, load_count_next;
    logic                        rd_pend_reg;
    logic                        rd_last_reg;

    logic [RCW-1:0] rows;
    logic [CCW-1:0] cols;
    logic [SZW-1:0] size, cnt_inc;
    logic           in_fire, issue, scan_start, scan_last;
    logic [AW-1:0]  scan_addr;
    logic [2:0]     occupancy;
    logic [1:0]     fifo_count;
    logic           out_pop;

    dzr_pkg::out_word_t push_word, head_word;
    logic [dzr_pkg::DATA_W-1:0] rd_data;

    // Effective block shape.
    assign rows = RCW'(dzr_pkg::clamp_dim(num_rows_reg, dzr_pkg::CFG_W'(MAX_ROWS)));
    assign cols = CCW'(dzr_pkg::clamp_dim(num_cols_reg, dzr_pkg::CFG_W'(MAX_COLS)));
    assign size = SZW'(rows) * SZW'(cols);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= dzr_pkg::CFG_DIM_RESET;
            num_cols_reg <= dzr_pkg::CFG_DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (dzr_pkg::cfg_reg_t'(cfg_index))
                dzr_pkg::REG_NUM_ROWS: num_rows_reg <= cfg_wdata;
                dzr_pkg::REG_NUM_COLS: num_cols_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign in_fire = s_tvalid && s_tready;
    assign out_pop = m_tvalid && m_tready;

    // Queue slots taken or promised by a read in flight, after this cycle's pop.
    assign occupancy = 3'(fifo_count) + 3'(rd_pend_reg) - 3'(out_pop);

    // Control: load words, then sweep the store in zigzag order.
    always_comb
    begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        s_tready        = 1'b0;
        issue           = 1'b0;
        scan_start      = 1'b0;
        cnt_inc         = SZW'(load_count_reg) + SZW'(1);
        unique case (state_reg)
            dzr_pkg::ST_LOAD:
            begin
                s_tready = 1'b1;
                if (in_fire)
                begin
                    if (cnt_inc >= size)
                    begin
                        load_count_next = '0;
                        scan_start      = 1'b1;
                        state_next      = dzr_pkg::ST_SCAN;
                    end
                    else
                        load_count_next = LCW'(cnt_inc);
                end
            end
            dzr_pkg::ST_SCAN:
            begin
                // Issue a read only when the queue will have room for it.
                issue = (occupancy < 3'(dzr_pkg::FIFO_DEPTH));
                if (issue && scan_last)
                    state_next = dzr_pkg::ST_LOAD;
            end
            default: state_next = dzr_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dzr_pkg::ST_LOAD;
            load_count_reg <= '0;
            rd_pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            rd_pend_reg    <= issue;
        end
    end

    // Travels alongside the read data; no reset needed.
    always_ff @(posedge clk)
    begin
        if (issue)
            rd_last_reg <= scan_last;
    end

    dzr_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (in_fire),
        .waddr (AW'(load_count_reg)),
        .wdata (s_tdata),
        .re    (issue),
        .raddr (scan_addr),
        .rdata (rd_data)
    );

    dzr_scan #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .RCW      (RCW),
        .CCW      (CCW),
        .AW       (AW)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (scan_start),
        .advance (issue),
        .rows    (rows),
        .cols    (cols),
        .addr    (scan_addr),
        .last    (scan_last)
    );

    assign push_word.data = rd_data;
    assign push_word.last = rd_last_reg;

    dzr_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rd_pend_reg),
        .push_word (push_word),
        .pop       (out_pop),
        .head_word (head_word),
        .not_empty (m_tvalid),
        .count     (fifo_count)
    );

    assign m_tdata = head_word.data;
    assign m_tlast = head_word.last;

endmodule

// ----- design/dzr_checker.sv -----
// Port-level checker for the diagonal zigzag reorder unit, bound to the top level.
// Depends on dzr_pkg for port widths.
module dzr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [dzr_pkg::DATA_W-1:0]    s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [dzr_pkg::DATA_W-1:0]    m_tdata,
    input logic                          m_tlast,
    input logic                          cfg_we,
    input logic [dzr_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [dzr_pkg::CFG_W-1:0]     cfg_wdata
);

    // Hold a stalled result word.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result word changed");

    // Input side closes only right after the word that completes a block.
    a_close_on_word: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid && s_tready))
        else $error("s_tready dropped without an accepted word");

    // Input side reopens only from the emission sweep, where no word is taken.
    a_open_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s_tready) && $past(rst_n) |-> !$past(s_tvalid && s_tready))
        else $error("s_tready rose right after an accepted word");

    // Offered input words carry known data.
    a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid |-> !$isunknown(s_tdata))
        else $error("input word offered with unknown data");

    // Write the shape registers only while the unit is idle.
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> s_tready && !m_tvalid && !$isunknown({cfg_index, cfg_wdata}))
        else $error("configuration written while the unit was busy");

endmodule

bind diagonal_zigzag_reorder_unit dzr_checker u_dzr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
);

// ----- tb/sv/tb_diagonal_zigzag_reorder_unit.sv -----
// Self-checking testbench for diagonal_zigzag_reorder_unit: drives row-major
// matrix words, predicts the zigzag diagonal read-out and checks every result.
// Depends on dzr_pkg and the design files of the unit; reads no files.
module tb_diagonal_zigzag_reorder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W     = dzr_pkg::DATA_W;
    localparam int CFG_W      = dzr_pkg::CFG_W;
    localparam int MAX_R      = dzr_pkg::DEF_MAX_ROWS;
    localparam int MAX_C      = dzr_pkg::DEF_MAX_COLS;
    localparam int STORE_SIZE = MAX_R * MAX_C;
    localparam int TAIL_WAIT  = 8;       // cycles to let the unit settle when idle
    localparam int RANDOM_ITEMS = 80;

    // One expected result word of the zigzag read-out.
    typedef struct {
        logic signed [DATA_W-1:0] elem;
        logic                     last;
    } scan_word_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [DATA_W-1:0]             s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [DATA_W-1:0]             m_tdata;
    logic                          m_tlast;
    logic                          cfg_we = 1'b0;
    logic [dzr_pkg::CFG_IDX_W-1:0] cfg_index = dzr_pkg::REG_NUM_ROWS;
    logic [CFG_W-1:0]              cfg_wdata = '0;

    diagonal_zigzag_reorder_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the element store, the fill count
    // and the raw register values as written.
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] elem_store [STORE_SIZE];
    logic [6:0]        fill_count = '0;
    logic [CFG_W-1:0]  rows_reg = dzr_pkg::CFG_DIM_RESET;
    logic [CFG_W-1:0]  cols_reg = dzr_pkg::CFG_DIM_RESET;

    scan_word_t        zigzag_q [$];     // expected results, oldest first
    logic [DATA_W-1:0] elem_q [$];       // words waiting to be driven

    int words_issued  = 0;
    int words_taken   = 0;
    int results_taken = 0;
    int results_seen  = 0;
    int blocks_done   = 0;
    int error_count   = 0;
    int items_total   = 0;

    bit tx_burst = 1'b0;                 // sender runs without gaps
    bit rx_burst = 1'b0;                 // receiver runs without stalls
    int gap_left   = 0;
    int stall_left = 0;

    // Zero reads as one, anything above the maximum reads as the maximum.
    function automatic int eff_dim(input logic [CFG_W-1:0] raw, input int maxv);
        int v;
        v = raw;
        if (v == 0)
            v = 1;
        else if (v > maxv)
            v = maxv;
        return v;
    endfunction

    // Store one element; on block completion queue the whole zigzag read-out.
    task automatic absorb_element(input logic [DATA_W-1:0] elem);
        int nr;
        int nc;
        int blk;
        int d;
        int r;
        int c;
        int n;
        scan_word_t w;
        nr  = eff_dim(rows_reg, MAX_R);
        nc  = eff_dim(cols_reg, MAX_C);
        blk = nr * nc;
        elem_store[fill_count[5:0]] = elem;
        fill_count = fill_count + 7'd1;
        if (fill_count >= blk)
        begin
            fill_count = '0;
            blocks_done++;
            n = 0;
            for (d = 0; d < nr + nc - 1; d++)
            begin
                // even diagonals climb from the lowest valid row,
                // odd ones descend from the highest valid column
                if (d % 2 == 0)
                begin
                    r = (d < nr - 1) ? d : nr - 1;
                    c = d - r;
                end
                else
                begin
                    c = (d < nc - 1) ? d : nc - 1;
                    r = d - c;
                end
                while (r >= 0 && c >= 0 && r < nr && c < nc)
                begin
                    w.elem = elem_store[r * nc + c];
                    w.last = (n == blk - 1);
                    zigzag_q = {zigzag_q, w};
                    n++;
                    if (d % 2 == 0)
                    begin
                        r--;
                        c++;
                    end
                    else
                    begin
                        r++;
                        c--;
                    end
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: present the next queued word at the falling edge, hold it
    // until taken, then wait the drawn gap.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        logic              nxt_valid;
        logic [DATA_W-1:0] nxt_data;
        if (rst_n)
        begin
            nxt_valid = s_tvalid;
            nxt_data  = s_tdata;
            // drop valid once the held word went through
            if (s_tvalid && words_taken == words_issued)
                nxt_valid = 1'b0;
            if (!nxt_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (elem_q.size() > 0)
                begin
                    nxt_data  = elem_q.pop_front();
                    nxt_valid = 1'b1;
                    words_issued++;
                    gap_left = tx_burst ? 0 : $urandom_range(0, 8);
                end
            end
            s_tvalid <= nxt_valid;
            s_tdata  <= nxt_data;
        end
    end

    // Sink: draw a fresh stall after every result taken.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (results_seen != results_taken)
            begin
                results_seen = results_taken;
                stall_left = rx_burst ? 0 : $urandom_range(0, 8);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge; feed accepted
    // input words to the predictor and check each result word.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        scan_word_t exp_w;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                words_taken++;
                absorb_element(s_tdata);
            end
            if (m_tvalid && m_tready)
            begin
                results_taken++;
                if (zigzag_q.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("[%0t] unexpected result: data=%0d last=%0b",
                                 $realtime, $signed(m_tdata), m_tlast);
                end
                else
                begin
                    exp_w = zigzag_q.pop_front();
                    if (m_tdata !== exp_w.elem || m_tlast !== exp_w.last)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("[%0t] mismatch: data exp %0d got %0d, last exp %0b got %0b",
                                     $realtime, exp_w.elem, $signed(m_tdata),
                                     exp_w.last, m_tlast);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly uniform values, now and then an extreme of the signed range, minus one or zero.
    function automatic logic [DATA_W-1:0] rand_elem();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 11))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2:       v = 32'hFFFF_FFFF;
            3:       v = 32'h0000_0000;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic queue_random(input int count);
        int i;
        for (i = 0; i < count; i++)
            elem_q = {elem_q, rand_elem()};
        items_total += count;
    endtask

    // Hold until every word is in and every expected result is out, then
    // let the unit settle for TAIL_WAIT in case a partial block is pending.
    task automatic wait_idle();
        while (!(elem_q.size() == 0 && words_taken == words_issued &&
                 zigzag_q.size() == 0))
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
    endtask

    // Write one dimension register at the falling edge; only call when idle.
    task automatic write_dim(input dzr_pkg::cfg_reg_t idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == dzr_pkg::REG_NUM_ROWS)
            rows_reg = val;
        else
            cols_reg = val;
    endtask

    task automatic set_shape(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] c);
        write_dim(dzr_pkg::REG_NUM_ROWS, r);
        write_dim(dzr_pkg::REG_NUM_COLS, c);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int rand_items;
        int phase;
        int nr;
        int nc;
        logic [CFG_W-1:0] r_raw;
        logic [CFG_W-1:0] c_raw;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: zero in both registers means a 1x1 block, so every
        // word comes straight back marked last; send the signed extremes.
        set_shape(4'd0, 4'd0);
        elem_q = {elem_q, 32'h8000_0000};
        elem_q = {elem_q, 32'h7FFF_FFFF};
        elem_q = {elem_q, 32'h0000_0000};
        elem_q = {elem_q, 32'hFFFF_FFFF};
        items_total += 4;
        wait_idle();

        // Directed: 2x3 block, both diagonal directions and a clipped corner.
        set_shape(4'd2, 4'd3);
        queue_random(6);
        wait_idle();

        // Change the shape mid-way: start 3x3, then switch to an oversized row
        // count (clips to the maximum) with one column before completing it.
        set_shape(4'd3, 4'd3);
        queue_random(2);
        wait_idle();
        set_shape(4'd15, 4'd1);
        queue_random(6);
        wait_idle();

        // Shrink the block mid-way below the words already loaded: the next
        // word completes it at once.
        set_shape(4'd4, 4'd4);
        queue_random(5);
        wait_idle();
        set_shape(4'd2, 4'd2);
        queue_random(1);
        wait_idle();

        // Random part: full-size block and the one-row extreme first, then
        // small random shapes with occasional out-of-range values.
        rand_items = 0;
        phase = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            case (phase)
                0: begin r_raw = 4'd8; c_raw = 4'd8; end
                1: begin r_raw = 4'd1; c_raw = 4'd8; end
                default:
                begin
                    r_raw = 4'($urandom_range(1, 3));
                    c_raw = 4'($urandom_range(1, 3));
                    // now and then one register out of range: zero or too large
                    if ($urandom_range(0, 3) == 0)
                    begin
                        if ($urandom_range(0, 1) == 0)
                            r_raw = ($urandom_range(0, 1) == 0) ? 4'd0
                                                                : 4'($urandom_range(9, 15));
                        else
                            c_raw = ($urandom_range(0, 1) == 0) ? 4'd0
                                                                : 4'($urandom_range(9, 15));
                    end
                end
            endcase
            set_shape(r_raw, c_raw);
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            nr = eff_dim(r_raw, MAX_R);
            nc = eff_dim(c_raw, MAX_C);
            queue_random(nr * nc);
            rand_items += nr * nc;
            // the sender pauses here until every expected result is back
            wait_idle();
            phase++;
        end

        repeat (20) @(posedge clk);
        $display("Covered %0d words in %0d blocks, %0d results checked, shapes 1x1 to 8x8.",
                 items_total, blocks_done, results_taken);
        $display("Included out-of-range dimensions and shape changes inside a block.");
        if (error_count == 0 && zigzag_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
        begin
            $display("%0d mismatches, %0d results outstanding", error_count, zigzag_q.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2ms;
        $display("timeout");
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
design/dzr_pkg.sv
design/dzr_store.sv
design/dzr_scan.sv
design/dzr_out_fifo.sv
design/diagonal_zigzag_reorder_unit.sv
design/dzr_checker.sv
tb/sv/tb_diagonal_zigzag_reorder_unit.sv
